/* hdl/mfb_pkg.sv */
// ----------------------------------------------------------------------------
// mfb_pkg
// Shared types and constants for the monochrome framebuffer draw/flush core.
// ----------------------------------------------------------------------------
package mfb_pkg;

    localparam int SCREEN_W_DEF = 128;
    localparam int SCREEN_H_DEF = 64;

    localparam int CMD_W     = 3;
    localparam int XY_W      = 9;
    localparam int SZ_W      = 8;
    localparam int ROW_W     = 6;
    localparam int CRD_W     = 11;
    localparam int BYTE_W    = 8;
    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 8;

    // slave tdata layout
    localparam int POSX_LSB = 0;
    localparam int POSY_LSB = 9;
    localparam int RW_LSB   = 18;
    localparam int RH_LSB   = 26;
    localparam int ON_BIT   = 34;
    localparam int ROW_LSB  = 35;

    localparam logic [BYTE_W-1:0] PAGE_CMD   = 8'hB0;
    localparam logic [BYTE_W-1:0] COL_LO_CMD = 8'h00;
    localparam logic [BYTE_W-1:0] COL_HI_CMD = 8'h10;
    localparam logic [BYTE_W-1:0] COL_NIB    = 8'h0F;

    typedef enum logic [CMD_W-1:0] {
        CMD_CLEAR   = 3'd0,
        CMD_PIXEL   = 3'd1,
        CMD_OUTLINE = 3'd2,
        CMD_FILL    = 3'd3,
        CMD_FLUSH   = 3'd4
    } t_cmd;

    typedef enum logic [1:0] {
        DOP_CLEAR,
        DOP_PIXEL,
        DOP_OUTLINE,
        DOP_FILL
    } t_draw_op;

    typedef struct packed {
        t_draw_op               op;
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic [SZ_W-1:0]        w;
        logic [SZ_W-1:0]        h;
        logic                   on;
    } t_draw_req;

    typedef enum logic [2:0] {
        D_IDLE,
        D_CLEAR,
        D_BOUND,
        D_CLIP,
        D_RD,
        D_WR
    } t_draw_state;

    typedef enum logic [1:0] {
        F_IDLE,
        F_HDR,
        F_RD,
        F_DAT
    } t_flush_state;

    typedef enum logic [1:0] {
        HDR_PAGE,
        HDR_COL_LO,
        HDR_COL_HI
    } t_hdr_sel;

endpackage

/* hdl/mono_framebuffer_draw_flush_core.sv */
// ----------------------------------------------------------------------------
// mono_framebuffer_draw_flush_core
// 1-bit-per-pixel framebuffer with rectangle blitter and row flusher.
// ----------------------------------------------------------------------------
// One command word at a time; the frame store is a single RAM with one write
// and one registered read port, and every byte access goes through it. After
// reset a clearing pass over all ROW_BYTES*SCREEN_H bytes (1024 at 128x64) runs
// with s_axis_tready low; the clear command runs the same pass. Pixel: one
// read-modify-write of its byte, none when off screen. Fill: a read, then a
// write, per byte touched, nothing when a size is zero. Outline: four passes
// (top, bottom, left, right edges), each a read and a write per byte touched.
// Flush: 2 or 3 command words (3 for row 0) then ROW_BYTES data words, paced
// by m_axis_tready. The next command is taken while the last result word
// still waits in the output register.
// ----------------------------------------------------------------------------
module mono_framebuffer_draw_flush_core #(
    parameter int SCREEN_W = mfb_pkg::SCREEN_W_DEF,
    parameter int SCREEN_H = mfb_pkg::SCREEN_H_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // pos_x[8:0], pos_y[17:9], rect_w[25:18], rect_h[33:26], pixel_on[34],
    // flush_row[40:35], zero fill above
    input  logic [mfb_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    // cmd[2:0]
    input  logic [mfb_pkg::CMD_W-1:0]       s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // out_byte[7:0]
    output logic [mfb_pkg::M_TDATA_W-1:0]   m_axis_tdata,
    // is_data[0]
    output logic [0:0]                      m_axis_tuser,
    output logic                            m_axis_tlast
);

    localparam int ROW_BYTES   = (SCREEN_W + 7) / 8;
    localparam int FRAME_BYTES = ROW_BYTES * SCREEN_H;
    localparam int AW          = $clog2(FRAME_BYTES);
    localparam int BW          = mfb_pkg::BYTE_W;

    logic                      accept;
    logic                      draw_busy, flush_busy;
    logic                      draw_start, flush_start;
    mfb_pkg::t_draw_req        draw_req;
    logic [mfb_pkg::ROW_W-1:0] flush_row;
    logic                      pixel_on;

    logic          draw_rd_en, flush_rd_en, draw_we;
    logic [AW-1:0] draw_rd_addr, flush_rd_addr, draw_waddr;
    logic [BW-1:0] draw_wdata, rd_data;
    logic          is_data;

    assign s_axis_tready = !draw_busy && !flush_busy;
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign flush_row = s_axis_tdata[mfb_pkg::ROW_LSB +: mfb_pkg::ROW_W];
    assign pixel_on  = s_axis_tdata[mfb_pkg::ON_BIT];

    always_comb begin
        draw_start  = 1'b0;
        flush_start = 1'b0;
        draw_req.x  = $signed(s_axis_tdata[mfb_pkg::POSX_LSB +: mfb_pkg::XY_W]);
        draw_req.y  = $signed(s_axis_tdata[mfb_pkg::POSY_LSB +: mfb_pkg::XY_W]);
        draw_req.w  = s_axis_tdata[mfb_pkg::RW_LSB +: mfb_pkg::SZ_W];
        draw_req.h  = s_axis_tdata[mfb_pkg::RH_LSB +: mfb_pkg::SZ_W];
        draw_req.on = 1'b1;
        draw_req.op = mfb_pkg::DOP_CLEAR;
        unique case (s_axis_tuser)
            mfb_pkg::CMD_CLEAR: begin
                draw_start = accept;
            end
            mfb_pkg::CMD_PIXEL: begin
                draw_start  = accept;
                draw_req.op = mfb_pkg::DOP_PIXEL;
                draw_req.on = pixel_on;
            end
            mfb_pkg::CMD_OUTLINE: begin
                draw_start  = accept;
                draw_req.op = mfb_pkg::DOP_OUTLINE;
            end
            mfb_pkg::CMD_FILL: begin
                draw_start  = accept;
                draw_req.op = mfb_pkg::DOP_FILL;
            end
            mfb_pkg::CMD_FLUSH: begin
                flush_start = accept && (int'(flush_row) < SCREEN_H);
            end
            default: begin
            end
        endcase
    end

    mfb_ram #(
        .WIDTH (BW),
        .DEPTH (FRAME_BYTES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (draw_we),
        .i_waddr (draw_waddr),
        .i_wdata (draw_wdata),
        .i_re    (draw_rd_en || flush_rd_en),
        .i_raddr (flush_busy ? flush_rd_addr : draw_rd_addr),
        .o_rdata (rd_data)
    );

    mfb_draw #(
        .SCREEN_W (SCREEN_W),
        .SCREEN_H (SCREEN_H)
    ) u_draw (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (draw_start),
        .i_req     (draw_req),
        .o_busy    (draw_busy),
        .o_rd_en   (draw_rd_en),
        .o_rd_addr (draw_rd_addr),
        .i_rd_data (rd_data),
        .o_we      (draw_we),
        .o_waddr   (draw_waddr),
        .o_wdata   (draw_wdata)
    );

    mfb_flush #(
        .SCREEN_W (SCREEN_W),
        .SCREEN_H (SCREEN_H)
    ) u_flush (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (flush_start),
        .i_row     (flush_row),
        .o_busy    (flush_busy),
        .o_rd_en   (flush_rd_en),
        .o_rd_addr (flush_rd_addr),
        .i_rd_data (rd_data),
        .o_tvalid  (m_axis_tvalid),
        .i_tready  (m_axis_tready),
        .o_tdata   (m_axis_tdata),
        .o_is_data (is_data),
        .o_last    (m_axis_tlast)
    );

    assign m_axis_tuser = is_data;

endmodule

/* hdl/mfb_ram.sv */
// ----------------------------------------------------------------------------
// mfb_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module mfb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* hdl/mfb_draw.sv */
// ----------------------------------------------------------------------------
// mfb_draw
// Draw sequencer: clear sweep, and clipped rectangle spans applied to the
// frame store as byte-wide read-modify-write.
// ----------------------------------------------------------------------------
module mfb_draw #(
    parameter int SCREEN_W = mfb_pkg::SCREEN_W_DEF,
    parameter int SCREEN_H = mfb_pkg::SCREEN_H_DEF
) (
    input  logic                                         i_clk,
    input  logic                                         i_rst_n,
    input  logic                                         i_start,
    input  mfb_pkg::t_draw_req                           i_req,
    output logic                                         o_busy,
    output logic                                         o_rd_en,
    output logic [$clog2(((SCREEN_W+7)/8)*SCREEN_H)-1:0] o_rd_addr,
    input  logic [mfb_pkg::BYTE_W-1:0]                   i_rd_data,
    output logic                                         o_we,
    output logic [$clog2(((SCREEN_W+7)/8)*SCREEN_H)-1:0] o_waddr,
    output logic [mfb_pkg::BYTE_W-1:0]                   o_wdata
);

    localparam int ROW_BYTES   = (SCREEN_W + 7) / 8;
    localparam int FRAME_BYTES = ROW_BYTES * SCREEN_H;
    localparam int AW          = $clog2(FRAME_BYTES);
    localparam int XW          = $clog2(SCREEN_W);
    localparam int YW          = $clog2(SCREEN_H);
    localparam int BXW         = (ROW_BYTES > 1) ? $clog2(ROW_BYTES) : 1;
    localparam int CW          = mfb_pkg::CRD_W;

    localparam logic signed [CW-1:0] XMAX = CW'(SCREEN_W - 1);
    localparam logic signed [CW-1:0] YMAX = CW'(SCREEN_H - 1);
    localparam logic signed [CW-1:0] ZERO = '0;
    localparam logic signed [CW-1:0] ONE  = CW'(1);

    mfb_pkg::t_draw_state r_state, n_state;
    mfb_pkg::t_draw_req   r_req, n_req;
    logic [1:0]           r_pass, n_pass;
    logic [AW-1:0]        r_clr, n_clr;
    logic signed [CW-1:0] r_xl, n_xl, r_xr, n_xr, r_yt, n_yt, r_yb, n_yb;
    logic [XW-1:0]        r_cx0, n_cx0, r_cx1, n_cx1;
    logic [YW-1:0]        r_cy1, n_cy1, r_row, n_row;
    logic [BXW-1:0]       r_bx, n_bx;

    logic signed [CW-1:0] xs, ys, xe, ye, wv, hv;
    logic signed [CW-1:0] bxl, bxr, byt, byb;
    logic                 empty, last_pass;
    logic [XW-1:0]        cx0, cx1;
    logic [YW-1:0]        cy0, cy1;
    logic [BXW-1:0]       bx_first, bx_last;
    logic [2:0]           lo, hi;
    logic [7:0]           mask;
    logic [AW-1:0]        addr;

    // span bounds for the current pass
    always_comb begin
        xs = CW'(r_req.x);
        ys = CW'(r_req.y);
        wv = $signed({{(CW-mfb_pkg::SZ_W){1'b0}}, r_req.w});
        hv = $signed({{(CW-mfb_pkg::SZ_W){1'b0}}, r_req.h});
        xe = xs + wv - ONE;
        ye = ys + hv - ONE;
        bxl = xs;
        bxr = xe;
        byt = ys;
        byb = ye;
        unique case (r_req.op)
            mfb_pkg::DOP_PIXEL: begin
                bxr = xs;
                byb = ys;
            end
            mfb_pkg::DOP_OUTLINE: begin
                unique case (r_pass)
                    2'd0: byb = ys;
                    2'd1: byt = ye;
                    2'd2: bxr = xs;
                    2'd3: bxl = xe;
                endcase
            end
            mfb_pkg::DOP_FILL,
            mfb_pkg::DOP_CLEAR: begin
            end
        endcase
    end

    // clipping
    always_comb begin
        empty = (r_xr < ZERO) || (r_xl > XMAX) || (r_yb < ZERO) || (r_yt > YMAX)
             || (r_xl > r_xr) || (r_yt > r_yb);
        cx0 = (r_xl < ZERO) ? '0 : XW'(r_xl);
        cx1 = (r_xr > XMAX) ? XW'(XMAX) : XW'(r_xr);
        cy0 = (r_yt < ZERO) ? '0 : YW'(r_yt);
        cy1 = (r_yb > YMAX) ? YW'(YMAX) : YW'(r_yb);
    end

    // byte mask within the clipped span
    always_comb begin
        bx_first = BXW'(r_cx0 >> 3);
        bx_last  = BXW'(r_cx1 >> 3);
        lo = (r_bx == bx_first) ? r_cx0[2:0] : 3'd0;
        hi = (r_bx == bx_last)  ? r_cx1[2:0] : 3'd7;
        for (int k = 0; k < 8; k++) begin
            mask[7-k] = (3'(k) >= lo) && (3'(k) <= hi);
        end
    end

    assign addr      = AW'(int'(r_row) * ROW_BYTES + int'(r_bx));
    assign last_pass = (r_req.op != mfb_pkg::DOP_OUTLINE) || (r_pass == 2'd3);
    assign o_busy    = (r_state != mfb_pkg::D_IDLE);
    assign o_rd_addr = addr;

    always_comb begin
        n_state = r_state;
        n_req   = r_req;
        n_pass  = r_pass;
        n_clr   = r_clr;
        n_xl    = r_xl;
        n_xr    = r_xr;
        n_yt    = r_yt;
        n_yb    = r_yb;
        n_cx0   = r_cx0;
        n_cx1   = r_cx1;
        n_cy1   = r_cy1;
        n_row   = r_row;
        n_bx    = r_bx;
        o_rd_en = 1'b0;
        o_we    = 1'b0;
        o_waddr = addr;
        o_wdata = '0;
        unique case (r_state)
            mfb_pkg::D_IDLE: begin
                if (i_start) begin
                    n_req  = i_req;
                    n_pass = '0;
                    n_clr  = '0;
                    if (i_req.op == mfb_pkg::DOP_CLEAR) begin
                        n_state = mfb_pkg::D_CLEAR;
                    end else begin
                        n_state = mfb_pkg::D_BOUND;
                    end
                end
            end
            mfb_pkg::D_CLEAR: begin
                o_we    = 1'b1;
                o_waddr = r_clr;
                if (r_clr == AW'(FRAME_BYTES - 1)) begin
                    n_state = mfb_pkg::D_IDLE;
                end else begin
                    n_clr = r_clr + 1'b1;
                end
            end
            mfb_pkg::D_BOUND: begin
                if (r_req.op == mfb_pkg::DOP_FILL && (r_req.w == '0 || r_req.h == '0)) begin
                    n_state = mfb_pkg::D_IDLE;
                end else begin
                    n_xl    = bxl;
                    n_xr    = bxr;
                    n_yt    = byt;
                    n_yb    = byb;
                    n_state = mfb_pkg::D_CLIP;
                end
            end
            mfb_pkg::D_CLIP: begin
                if (empty) begin
                    if (last_pass) begin
                        n_state = mfb_pkg::D_IDLE;
                    end else begin
                        n_pass  = r_pass + 1'b1;
                        n_state = mfb_pkg::D_BOUND;
                    end
                end else begin
                    n_cx0   = cx0;
                    n_cx1   = cx1;
                    n_cy1   = cy1;
                    n_row   = cy0;
                    n_bx    = BXW'(cx0 >> 3);
                    n_state = mfb_pkg::D_RD;
                end
            end
            mfb_pkg::D_RD: begin
                o_rd_en = 1'b1;
                n_state = mfb_pkg::D_WR;
            end
            mfb_pkg::D_WR: begin
                o_we    = 1'b1;
                o_wdata = r_req.on ? (i_rd_data | mask) : (i_rd_data & ~mask);
                if (r_bx == bx_last) begin
                    if (r_row == r_cy1) begin
                        if (last_pass) begin
                            n_state = mfb_pkg::D_IDLE;
                        end else begin
                            n_pass  = r_pass + 1'b1;
                            n_state = mfb_pkg::D_BOUND;
                        end
                    end else begin
                        n_row   = r_row + 1'b1;
                        n_bx    = bx_first;
                        n_state = mfb_pkg::D_RD;
                    end
                end else begin
                    n_bx    = r_bx + 1'b1;
                    n_state = mfb_pkg::D_RD;
                end
            end
            default: begin
                n_state = mfb_pkg::D_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mfb_pkg::D_CLEAR;
            r_clr   <= '0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req  <= n_req;
        r_pass <= n_pass;
        r_xl   <= n_xl;
        r_xr   <= n_xr;
        r_yt   <= n_yt;
        r_yb   <= n_yb;
        r_cx0  <= n_cx0;
        r_cx1  <= n_cx1;
        r_cy1  <= n_cy1;
        r_row  <= n_row;
        r_bx   <= n_bx;
    end

endmodule

/* hdl/mfb_flush.sv */
// ----------------------------------------------------------------------------
// mfb_flush
// Row flusher: page (row 0 only) and column-address commands, then the row's
// bytes bit-reversed, through a one-word output register.
// ----------------------------------------------------------------------------
module mfb_flush #(
    parameter int SCREEN_W = mfb_pkg::SCREEN_W_DEF,
    parameter int SCREEN_H = mfb_pkg::SCREEN_H_DEF
) (
    input  logic                                         i_clk,
    input  logic                                         i_rst_n,
    input  logic                                         i_start,
    input  logic [mfb_pkg::ROW_W-1:0]                    i_row,
    output logic                                         o_busy,
    output logic                                         o_rd_en,
    output logic [$clog2(((SCREEN_W+7)/8)*SCREEN_H)-1:0] o_rd_addr,
    input  logic [mfb_pkg::BYTE_W-1:0]                   i_rd_data,
    output logic                                         o_tvalid,
    input  logic                                         i_tready,
    output logic [mfb_pkg::BYTE_W-1:0]                   o_tdata,
    output logic                                         o_is_data,
    output logic                                         o_last
);

    localparam int ROW_BYTES   = (SCREEN_W + 7) / 8;
    localparam int FRAME_BYTES = ROW_BYTES * SCREEN_H;
    localparam int AW          = $clog2(FRAME_BYTES);
    localparam int BXW         = (ROW_BYTES > 1) ? $clog2(ROW_BYTES) : 1;
    localparam int BW          = mfb_pkg::BYTE_W;

    function automatic logic [BW-1:0] f_mirror(input logic [BW-1:0] v);
        logic [BW-1:0] r;
        for (int k = 0; k < BW; k++) begin
            r[k] = v[BW-1-k];
        end
        return r;
    endfunction

    mfb_pkg::t_flush_state     r_state, n_state;
    mfb_pkg::t_hdr_sel         r_hidx, n_hidx;
    logic [mfb_pkg::ROW_W-1:0] r_row, n_row;
    logic [BXW-1:0]            r_bx, n_bx;
    logic                      r_vld, n_vld;
    logic [BW-1:0]             r_byte, n_byte;
    logic                      r_isd, n_isd;
    logic                      r_last, n_last;

    logic          slot_free;
    logic          bx_end;
    logic [BW-1:0] col;
    logic [BW-1:0] hdr;

    assign slot_free = !r_vld || i_tready;
    assign bx_end    = (r_bx == BXW'(ROW_BYTES - 1));
    assign col       = BW'(SCREEN_H - 1) - BW'(r_row);
    assign o_rd_addr = AW'(int'(r_row) * ROW_BYTES + int'(r_bx));
    assign o_busy    = (r_state != mfb_pkg::F_IDLE);

    always_comb begin
        unique case (r_hidx)
            mfb_pkg::HDR_PAGE:   hdr = mfb_pkg::PAGE_CMD;
            mfb_pkg::HDR_COL_LO: hdr = mfb_pkg::COL_LO_CMD + (col & mfb_pkg::COL_NIB);
            mfb_pkg::HDR_COL_HI: hdr = mfb_pkg::COL_HI_CMD + (col >> 4);
            default:             hdr = mfb_pkg::PAGE_CMD;
        endcase
    end

    always_comb begin
        n_state = r_state;
        n_hidx  = r_hidx;
        n_row   = r_row;
        n_bx    = r_bx;
        n_vld   = r_vld && !i_tready;
        n_byte  = r_byte;
        n_isd   = r_isd;
        n_last  = r_last;
        o_rd_en = 1'b0;
        unique case (r_state)
            mfb_pkg::F_IDLE: begin
                if (i_start) begin
                    n_row   = i_row;
                    n_bx    = '0;
                    n_hidx  = (i_row == '0) ? mfb_pkg::HDR_PAGE : mfb_pkg::HDR_COL_LO;
                    n_state = mfb_pkg::F_HDR;
                end
            end
            mfb_pkg::F_HDR: begin
                if (slot_free) begin
                    n_vld  = 1'b1;
                    n_byte = hdr;
                    n_isd  = 1'b0;
                    n_last = 1'b0;
                    if (r_hidx == mfb_pkg::HDR_COL_HI) begin
                        n_state = mfb_pkg::F_RD;
                    end else if (r_hidx == mfb_pkg::HDR_PAGE) begin
                        n_hidx = mfb_pkg::HDR_COL_LO;
                    end else begin
                        n_hidx = mfb_pkg::HDR_COL_HI;
                    end
                end
            end
            mfb_pkg::F_RD: begin
                o_rd_en = 1'b1;
                n_state = mfb_pkg::F_DAT;
            end
            mfb_pkg::F_DAT: begin
                if (slot_free) begin
                    n_vld  = 1'b1;
                    n_byte = f_mirror(i_rd_data);
                    n_isd  = 1'b1;
                    n_last = bx_end;
                    if (bx_end) begin
                        n_state = mfb_pkg::F_IDLE;
                    end else begin
                        n_bx    = r_bx + 1'b1;
                        n_state = mfb_pkg::F_RD;
                    end
                end
            end
            default: begin
                n_state = mfb_pkg::F_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mfb_pkg::F_IDLE;
            r_vld   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_vld   <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hidx <= n_hidx;
        r_row  <= n_row;
        r_bx   <= n_bx;
        r_byte <= n_byte;
        r_isd  <= n_isd;
        r_last <= n_last;
    end

    assign o_tvalid  = r_vld;
    assign o_tdata   = r_byte;
    assign o_is_data = r_isd;
    assign o_last    = r_last;

endmodule

/* hdl/mfb_checker.sv */
// ----------------------------------------------------------------------------
// mfb_checker
// Port-level checks for the framebuffer core, bound to the top level.
// ----------------------------------------------------------------------------
module mfb_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_s_tready,
    input logic                          i_m_tvalid,
    input logic                          i_m_tready,
    input logic [mfb_pkg::M_TDATA_W-1:0] i_m_tdata,
    input logic [0:0]                    i_m_tuser,
    input logic                          i_m_tlast
);

    // reset starts the clearing sweep, no command taken
    a_rst_clear: assert property (@(posedge i_clk) !i_rst_n |=> !i_s_tready)
        else $error("command accepted right after reset");

    // final word of a row is a data word
    a_last_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && i_m_tlast |-> i_m_tuser[0])
        else $error("tlast on a command word");

    // a flush in progress blocks new commands until its last word is queued
    a_flush_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && !i_m_tlast |-> !i_s_tready)
        else $error("command accepted mid flush");

    // stalled output word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && !i_m_tready |=>
            i_m_tvalid && $stable(i_m_tdata) && $stable(i_m_tuser) && $stable(i_m_tlast))
        else $error("output word changed while stalled");

endmodule

bind mono_framebuffer_draw_flush_core mfb_checker u_mfb_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tready (s_axis_tready),
    .i_m_tvalid (m_axis_tvalid),
    .i_m_tready (m_axis_tready),
    .i_m_tdata  (m_axis_tdata),
    .i_m_tuser  (m_axis_tuser),
    .i_m_tlast  (m_axis_tlast)
);
